// ----- rtl/hhbtb_pkg.sv -----
// ----------------------------------------------------------------------------
// hhbtb_pkg
// Shared sizes, entry layout and states of the history-hashed BTB.
// ----------------------------------------------------------------------------
package hhbtb_pkg;

  localparam int WAYS      = 4;
  localparam int SET_W     = 7;                    // sets are a power of two
  localparam int SETS      = 1 << SET_W;
  localparam int HIST_BITS = 7;
  localparam int ADDR_BITS = 64;
  localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W     = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic ACT_ACCESS  = 1'b0;
  localparam logic ACT_HISTORY = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [ADDR_BITS-1:0] target;
    logic [RANK_W-1:0]    rank;     // 0 = MRU, WAYS-1 = LRU
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

endpackage

// ----- rtl/history_hashed_branch_target_buffer.sv -----
// ----------------------------------------------------------------------------
// history_hashed_branch_target_buffer
// Set-associative BTB, set index = low address bits XOR global history.
// ----------------------------------------------------------------------------
// Each request is served in turn: the set row is read from a single-port
// synchronous RAM in the accept cycle, and in the following cycle the row is
// looked up, the result is loaded into the output register and the modified
// row (targets, valid bits, LRU ranks) is written back. The next request is
// taken in the cycle after that, so a new request is not accepted before the
// last one retires; a result still waiting at the output only holds the
// lookup cycle until the output register frees up. The RAM row
// holds every way of a set; a per-set "row written" flag, cleared at reset,
// makes an untouched set read as all ways invalid with ranks equal to the way
// index, so no clearing pass is needed. History requests only shift the
// global history and return the counter values with the other fields zero.
// ----------------------------------------------------------------------------
module history_hashed_branch_target_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [63:0] in_ins_addr,
  input  logic [63:0] in_branch_addr,
  input  logic        in_taken,
  input  logic [3:0]  in_ins_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [63:0] out_predicted_target,
  output logic        out_mispredict,
  output logic [31:0] out_access_count,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_mispredict_count
);

  localparam int AW = hhbtb_pkg::ADDR_BITS;
  localparam int RW = hhbtb_pkg::RANK_W;
  localparam int SW = hhbtb_pkg::SET_W;
  localparam int CW = hhbtb_pkg::CNT_W;

  // Set row storage
  hhbtb_pkg::row_t mem [hhbtb_pkg::SETS];
  logic [hhbtb_pkg::SETS-1:0] row_vld_r;

  hhbtb_pkg::state_t state_r, state_nxt;

  // Request registers
  logic          act_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] br_r;
  logic          taken_r;
  logic [AW-1:0] fall_r;
  logic [SW-1:0] set_r;
  hhbtb_pkg::row_t row_r;
  logic          rowv_r;

  logic [hhbtb_pkg::HIST_BITS-1:0] hist_r;
  logic [CW-1:0] acc_r, miss_r, mp_r;
  logic [CW-1:0] acc_nxt, miss_nxt, mp_nxt;

  // Output register
  logic          out_valid_r;
  logic          out_hit_r;
  logic [AW-1:0] out_pred_r;
  logic          out_mp_r;

  logic          in_acc;
  logic          advance;
  logic [SW-1:0] rd_set;

  hhbtb_pkg::row_t cur, wr_row;
  logic          hit;
  logic [RW-1:0] hway;
  logic          vfound;
  logic [RW-1:0] vict;
  logic [AW-1:0] pred;
  logic [AW-1:0] next_pc;
  logic          mp;
  logic          do_fill;
  logic          mru_en;
  logic [RW-1:0] mru_way;
  logic [RW-1:0] mru_rank;
  logic          mem_we;
  logic [hhbtb_pkg::WAYS-1:0] wr_rank_mask;

  assign in_ready = (state_r == hhbtb_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign advance  = (state_r == hhbtb_pkg::S_LOOK) && (!out_valid_r || out_ready);
  assign rd_set   = in_ins_addr[SW-1:0] ^ SW'(hist_r);

  // Sequence: take a request, look it up, retire it into the output register
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hhbtb_pkg::S_IDLE: if (in_acc)  state_nxt = hhbtb_pkg::S_LOOK;
      hhbtb_pkg::S_LOOK: if (advance) state_nxt = hhbtb_pkg::S_IDLE;
      default:                        state_nxt = hhbtb_pkg::S_IDLE;
    endcase
  end

  // Lookup, victim choice and row update
  always_comb begin
    for (int w = 0; w < hhbtb_pkg::WAYS; w++) begin
      if (rowv_r) begin
        cur[w] = row_r[w];
      end else begin
        cur[w].valid  = 1'b0;
        cur[w].tag    = '0;
        cur[w].target = '0;
        cur[w].rank   = RW'(w);
      end
    end

    hit  = 1'b0;
    hway = '0;
    for (int w = 0; w < hhbtb_pkg::WAYS; w++) begin
      if (!hit && cur[w].valid && (cur[w].tag == addr_r)) begin
        hit  = 1'b1;
        hway = RW'(w);
      end
    end

    // First invalid way, else the LRU way
    vfound = 1'b0;
    vict   = '0;
    for (int w = 0; w < hhbtb_pkg::WAYS; w++) begin
      if (!vfound && !cur[w].valid) begin
        vfound = 1'b1;
        vict   = RW'(w);
      end
    end
    if (!vfound) begin
      for (int w = 0; w < hhbtb_pkg::WAYS; w++) begin
        if (cur[w].rank == RW'(hhbtb_pkg::WAYS - 1)) vict = RW'(w);
      end
    end

    pred    = hit ? cur[hway].target : fall_r;
    next_pc = taken_r ? br_r : fall_r;
    mp      = (pred != next_pc);
    do_fill = taken_r && !hit && (br_r != fall_r);
    mru_en  = hit || do_fill;
    mru_way = hit ? hway : vict;

    wr_row = cur;
    if (hit && taken_r)  wr_row[hway].target = br_r;
    if (hit && !taken_r) wr_row[hway].valid  = 1'b0;
    if (do_fill) begin
      wr_row[vict].valid  = 1'b1;
      wr_row[vict].tag    = addr_r;
      wr_row[vict].target = br_r;
    end
    mru_rank = cur[mru_way].rank;
    if (mru_en) begin
      for (int w = 0; w < hhbtb_pkg::WAYS; w++) begin
        if (cur[w].rank < mru_rank) wr_row[w].rank = cur[w].rank + RW'(1);
      end
      wr_row[mru_way].rank = '0;
    end

    wr_rank_mask = '0;
    for (int w = 0; w < hhbtb_pkg::WAYS; w++) begin
      wr_rank_mask[wr_row[w].rank] = 1'b1;
    end
  end

  assign mem_we = advance && (act_r == hhbtb_pkg::ACT_ACCESS) && mru_en;

  // Saturating statistics
  always_comb begin
    acc_nxt  = acc_r;
    miss_nxt = miss_r;
    mp_nxt   = mp_r;
    if (advance && (act_r == hhbtb_pkg::ACT_ACCESS)) begin
      if (acc_r != hhbtb_pkg::CNT_MAX)         acc_nxt  = acc_r + CW'(1);
      if (!hit && miss_r != hhbtb_pkg::CNT_MAX) miss_nxt = miss_r + CW'(1);
      if (mp && mp_r != hhbtb_pkg::CNT_MAX)     mp_nxt   = mp_r + CW'(1);
    end
  end

  // Row RAM: read on accept, write back when the lookup retires
  always_ff @(posedge clk) begin
    if (in_acc) row_r <= mem[rd_set];
    if (mem_we) mem[set_r] <= wr_row;
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_action;
      addr_r  <= in_ins_addr[AW-1:0];
      br_r    <= in_branch_addr[AW-1:0];
      taken_r <= in_taken;
      fall_r  <= in_ins_addr[AW-1:0] + AW'(in_ins_size);
      set_r   <= rd_set;
      rowv_r  <= row_vld_r[rd_set];
    end
    if (advance) begin
      out_hit_r  <= (act_r == hhbtb_pkg::ACT_ACCESS) && hit;
      out_pred_r <= (act_r == hhbtb_pkg::ACT_ACCESS) ? pred : '0;
      out_mp_r   <= (act_r == hhbtb_pkg::ACT_ACCESS) && mp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hhbtb_pkg::S_IDLE;
      row_vld_r   <= '0;
      hist_r      <= '0;
      acc_r       <= '0;
      miss_r      <= '0;
      mp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      miss_r  <= miss_nxt;
      mp_r    <= mp_nxt;
      // Shift the taken bit into the history on a history request
      if (in_acc && (in_action == hhbtb_pkg::ACT_HISTORY)) begin
        hist_r <= hhbtb_pkg::HIST_BITS'({hist_r, in_taken});
      end
      if (mem_we) row_vld_r[set_r] <= 1'b1;
      if (advance)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_predicted_target = 64'(out_pred_r);
  assign out_mispredict       = out_mp_r;
  assign out_access_count     = acc_r;
  assign out_miss_count       = miss_r;
  assign out_mispredict_count = mp_r;

  // Ranks written back always form a permutation of the ways
  a_rank_perm: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (wr_rank_mask == '1))
    else $error("written LRU ranks are not a permutation");

  // A row is never written while a read for a new request is in flight
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_acc)
    else $error("row write overlaps a request read");

  // Miss count never runs ahead of the access count
  a_miss_le_acc: assert property (@(posedge clk) disable iff (!rst_n)
    miss_r <= acc_r)
    else $error("miss count exceeds access count");

  // A retired history request leaves the access count unchanged
  a_hist_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && act_r == hhbtb_pkg::ACT_HISTORY) |=> (acc_r == $past(acc_r)))
    else $error("history request changed the access count");

endmodule
